>>> sv/operand_access_unit_assert.svh
// assertion macros for the operand access unit
`ifndef OPERAND_ACCESS_UNIT_ASSERT_SVH
`define OPERAND_ACCESS_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define OAU_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define OAU_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/oau_pkg.sv
package oau_pkg;

   // operation codes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FLAG  = 2'd2;

   // operand kinds
   localparam logic [1:0] KIND_REG = 2'd0;
   localparam logic [1:0] KIND_IMM = 2'd1;
   localparam logic [1:0] KIND_MEM = 2'd2;

   // register parts
   localparam logic [1:0] PART_HIGH = 2'd1;
   localparam logic [1:0] PART_LOW  = 2'd2;

   // register indexes used by the address and flag logic
   localparam logic [3:0] REG_BX    = 4'd1;
   localparam logic [3:0] REG_BP    = 4'd5;
   localparam logic [3:0] REG_SI    = 4'd6;
   localparam logic [3:0] REG_DI    = 4'd7;
   localparam logic [3:0] REG_FLAGS = 4'd13;

   // addressing modes
   localparam logic [3:0] EA_BX_SI = 4'd1;
   localparam logic [3:0] EA_BX_DI = 4'd2;
   localparam logic [3:0] EA_BP_SI = 4'd3;
   localparam logic [3:0] EA_BP_DI = 4'd4;
   localparam logic [3:0] EA_SI    = 4'd5;
   localparam logic [3:0] EA_DI    = 4'd6;
   localparam logic [3:0] EA_BP    = 4'd7;
   localparam logic [3:0] EA_BX    = 4'd8;

   localparam logic [7:0] BYTE_MASK  = 8'hFF;
   localparam int         BYTE_SHIFT = 8;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // channel widths
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 32;

   // item class decided by the front
   typedef enum logic [2:0] {
      CMD_NOP    = 3'd0,
      CMD_IMM_RD = 3'd1,
      CMD_REG_RD = 3'd2,
      CMD_REG_WR = 3'd3,
      CMD_MEM_RD = 3'd4,
      CMD_MEM_WR = 3'd5,
      CMD_FLAG   = 3'd6
   } cmd_class_type;

   typedef struct packed {
      cmd_class_type      cls;
      logic [3:0]         reg_select;
      logic [1:0]         reg_part;
      logic [3:0]         ea_mode;
      logic signed [15:0] disp_value;
      logic               wide;
      logic [15:0]        data_value;
      logic [3:0]         flag_index;
      logic               flag_value;
   } cmd_type;

   // back status seen by the front
   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

>>> sv/oau_ram.sv
module oau_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/oau_front.sv
module oau_front
   import oau_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  back_status_type       status,
   input  logic                  q_full,
   output logic                  q_push,
   output cmd_type               q_cmd
);

   logic [1:0] operation;
   logic [1:0] operand_kind;

   // unpack the item and classify it: anything without an effect becomes a no-op
   always_comb begin
      operation          = req_tuser[1:0];
      operand_kind       = req_tuser[3:2];
      q_cmd.reg_select   = req_tdata[3:0];
      q_cmd.reg_part     = req_tdata[5:4];
      q_cmd.ea_mode      = req_tdata[9:6];
      q_cmd.disp_value   = req_tdata[25:10];
      q_cmd.wide         = req_tdata[26];
      q_cmd.data_value   = req_tdata[42:27];
      q_cmd.flag_index   = req_tdata[46:43];
      q_cmd.flag_value   = req_tdata[47];
      case (operation)
         OP_READ: begin
            case (operand_kind)
               KIND_REG: q_cmd.cls = CMD_REG_RD;
               KIND_IMM: q_cmd.cls = CMD_IMM_RD;
               KIND_MEM: q_cmd.cls = CMD_MEM_RD;
               default:  q_cmd.cls = CMD_NOP;
            endcase
         end
         OP_WRITE: begin
            case (operand_kind)
               KIND_REG: q_cmd.cls = CMD_REG_WR;
               KIND_MEM: q_cmd.cls = CMD_MEM_WR;
               default:  q_cmd.cls = CMD_NOP;
            endcase
         end
         OP_FLAG: q_cmd.cls = CMD_FLAG;
         default: q_cmd.cls = CMD_NOP;
      endcase
   end

   // accept while the queue has room and memory is not being cleared
   assign req_tready = !q_full && !status.clearing;
   assign q_push     = req_tvalid && req_tready;

endmodule

>>> sv/oau_queue.sv
module oau_queue
   import oau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff;
   logic [PtrW-1:0]   wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff;
   logic [PtrW-1:0]   rd_ptr_in;
   logic [CntW-1:0]   count_ff;
   logic [CntW-1:0]   count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CntW'(1);
         2'b01:   count_in = count_ff - CntW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd = entry_ff[rd_ptr_ff];
   assign full    = (count_ff == CntW'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);

endmodule

>>> sv/oau_back.sv
`include "operand_access_unit_assert.svh"

module oau_back
   import oau_pkg::*;
#(
   parameter int ADDR_BITS = 16,
   parameter int REG_COUNT = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  cmd_type               q_cmd,
   output logic                  q_pop,
   output back_status_type       status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int RegIdxW = $clog2(REG_COUNT);
   localparam int EaW     = (ADDR_BITS > 16) ? ADDR_BITS : 16;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_LOW   = 4'b0100,
      S_HIGH  = 4'b1000
   } state_type;

   state_type              state_ff;
   state_type              state_in;
   logic [ADDR_BITS-1:0]   clr_ff;
   logic [ADDR_BITS-1:0]   clr_in;
   logic [ADDR_BITS-1:0]   ea_ff;
   logic [ADDR_BITS-1:0]   ea_in;
   logic [7:0]             lo_ff;
   logic [7:0]             lo_in;
   logic [7:0]             hi_data_ff;
   logic [7:0]             hi_data_in;
   logic                   cur_write_ff;
   logic                   cur_write_in;
   logic                   cur_wide_ff;
   logic                   cur_wide_in;
   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;
   logic [15:0]            rf_ff [REG_COUNT];

   logic                   rf_we;
   logic [RegIdxW-1:0]     rf_widx;
   logic [15:0]            rf_wdata;
   logic                   ram_we;
   logic [ADDR_BITS-1:0]   ram_addr;
   logic [7:0]             ram_wdata;
   logic [7:0]             ram_rdata;
   logic                   result_load;
   logic [15:0]            result_rv;
   logic [15:0]            result_ea;
   logic                   slot_free;
   logic [ADDR_BITS-1:0]   ea_next;
   logic                   reg_in_range;
   logic [15:0]            sel_word;
   logic [15:0]            sel_value;
   logic [15:0]            base_word;
   logic [15:0]            index_word;
   logic [EaW-1:0]         ea_sum;
   logic [ADDR_BITS-1:0]   ea_calc;
   logic [15:0]            flag_bit;

   // register read at the selected index and part
   always_comb begin
      reg_in_range = ({1'b0, q_cmd.reg_select} < 5'(REG_COUNT));
      sel_word     = reg_in_range ? rf_ff[q_cmd.reg_select[RegIdxW-1:0]] : '0;
      case (q_cmd.reg_part)
         PART_HIGH: sel_value = {8'h00, sel_word[15:BYTE_SHIFT] & BYTE_MASK};
         PART_LOW:  sel_value = {8'h00, sel_word[7:0] & BYTE_MASK};
         default:   sel_value = sel_word;
      endcase
   end

   // effective address: base + index + displacement, wrapped to the memory
   always_comb begin
      case (q_cmd.ea_mode)
         EA_BX_SI, EA_BX_DI, EA_BX: base_word = rf_ff[RegIdxW'(REG_BX)];
         EA_BP_SI, EA_BP_DI, EA_BP: base_word = rf_ff[RegIdxW'(REG_BP)];
         default:                   base_word = '0;
      endcase
      case (q_cmd.ea_mode)
         EA_BX_SI, EA_BP_SI, EA_SI: index_word = rf_ff[RegIdxW'(REG_SI)];
         EA_BX_DI, EA_BP_DI, EA_DI: index_word = rf_ff[RegIdxW'(REG_DI)];
         default:                   index_word = '0;
      endcase
      ea_sum  = EaW'(base_word) + EaW'(index_word) + EaW'(q_cmd.disp_value);
      ea_calc = ea_sum[ADDR_BITS-1:0];
   end

   assign ea_next   = ea_ff + ADDR_BITS'(1);
   assign flag_bit  = 16'(1) << q_cmd.flag_index;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ea_in        = ea_ff;
      lo_in        = lo_ff;
      hi_data_in   = hi_data_ff;
      cur_write_in = cur_write_ff;
      cur_wide_in  = cur_wide_ff;
      q_pop        = 1'b0;
      rf_we        = 1'b0;
      rf_widx      = q_cmd.reg_select[RegIdxW-1:0];
      rf_wdata     = q_cmd.data_value;
      ram_we       = 1'b0;
      ram_addr     = ea_ff;
      ram_wdata    = hi_data_ff;
      result_load  = 1'b0;
      result_rv    = '0;
      result_ea    = '0;
      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + ADDR_BITS'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty && slot_free) begin
               q_pop        = 1'b1;
               ea_in        = ea_calc;
               hi_data_in   = q_cmd.data_value[15:BYTE_SHIFT];
               cur_wide_in  = q_cmd.wide;
               cur_write_in = (q_cmd.cls == CMD_MEM_WR);
               ram_addr     = ea_calc;
               case (q_cmd.cls)
                  CMD_IMM_RD: begin
                     result_load = 1'b1;
                     result_rv   = q_cmd.data_value;
                  end
                  CMD_REG_RD: begin
                     result_load = 1'b1;
                     result_rv   = sel_value;
                  end
                  CMD_REG_WR: begin
                     result_load = 1'b1;
                     rf_we       = reg_in_range;
                     case (q_cmd.reg_part)
                        PART_HIGH: rf_wdata = {q_cmd.data_value[7:0], sel_word[7:0]};
                        PART_LOW:  rf_wdata = {sel_word[15:BYTE_SHIFT], q_cmd.data_value[7:0]};
                        default:   rf_wdata = q_cmd.data_value;
                     endcase
                  end
                  CMD_FLAG: begin
                     result_load = 1'b1;
                     rf_we       = 1'b1;
                     rf_widx     = RegIdxW'(REG_FLAGS);
                     rf_wdata    = q_cmd.flag_value ? (rf_ff[RegIdxW'(REG_FLAGS)] | flag_bit)
                                                    : (rf_ff[RegIdxW'(REG_FLAGS)] & ~flag_bit);
                  end
                  CMD_MEM_RD: begin
                     state_in = S_LOW;
                  end
                  CMD_MEM_WR: begin
                     ram_we    = 1'b1;
                     ram_wdata = q_cmd.data_value[7:0];
                     if (q_cmd.wide) begin
                        state_in = S_HIGH;
                     end else begin
                        result_load = 1'b1;
                        result_ea   = 16'(ea_calc);
                     end
                  end
                  default: begin
                     result_load = 1'b1;
                  end
               endcase
            end
         end
         S_LOW: begin
            // low byte of a read is back from the memory
            lo_in = ram_rdata;
            if (cur_wide_ff) begin
               ram_addr = ea_next;
               state_in = S_HIGH;
            end else begin
               result_load = 1'b1;
               result_rv   = {8'h00, ram_rdata};
               result_ea   = 16'(ea_ff);
               state_in    = S_IDLE;
            end
         end
         S_HIGH: begin
            // high byte at the next address, wrapping at the top
            ram_addr    = ea_next;
            result_load = 1'b1;
            result_ea   = 16'(ea_ff);
            state_in    = S_IDLE;
            if (cur_write_ff) begin
               ram_we    = 1'b1;
               ram_wdata = hi_data_ff;
            end else begin
               result_rv = {ram_rdata, lo_ff};
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ea_ff        <= ea_in;
      lo_ff        <= lo_in;
      hi_data_ff   <= hi_data_in;
      cur_write_ff <= cur_write_in;
      cur_wide_ff  <= cur_wide_in;
      if (result_load) begin
         rsp_data_ff <= {result_ea, result_rv};
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            rf_ff[i] <= '0;
         end
      end else if (rf_we) begin
         rf_ff[rf_widx] <= rf_wdata;
      end
   end

   oau_ram #(
      .WIDTH (8),
      .DEPTH (2 ** ADDR_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign status.clearing = (state_ff == S_CLEAR);
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

   // checks
   `OAU_ASSERT_SAME(a_no_pop_in_clear, state_ff == S_CLEAR, !q_pop, "item taken during memory clear")
   `OAU_ASSERT_SAME(a_result_slot_free, result_load, !rsp_valid_ff || rsp_tready, "result overwrote a pending item")
   `OAU_ASSERT_SAME(a_high_only_wide, state_ff == S_HIGH, cur_wide_ff, "high byte phase on a byte access")
   `OAU_ASSERT_SAME(a_no_write_in_low, state_ff == S_LOW, !ram_we && !rf_we, "write during read phase")
   `OAU_ASSERT_NEXT(a_mem_read_continues, q_pop && q_cmd.cls == CMD_MEM_RD, state_ff == S_LOW, "memory read lost its data phase")

endmodule

>>> sv/operand_access_unit.sv
// Operand access unit: fourteen 16-bit registers (byte halves addressable) plus a byte memory of
// 2**ADDR_BITS locations, both zero after reset. Each req item reads a register, immediate or
// memory operand, writes a register or memory operand, or sets or clears one flags bit; each
// gives exactly one rsp item with the value read and the effective address. After reset the
// memory is cleared one byte a cycle, and req_tready stays low until the clear is done.
// Items pass a two-entry queue into the execution sequencer, whose steps are set by the single
// memory port: register, immediate, flag and byte-write items finish in the idle state, byte
// reads add a low-byte state, word writes a high-byte state, word reads both; results sit in an
// output register while the next item is already queued.
module operand_access_unit
   import oau_pkg::*;
#(
   parameter int ADDR_BITS = 16,
   parameter int REG_COUNT = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // reg_select, reg_part, ea_mode, disp_value, wide, data_value, flag_index, flag_value
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation, operand_kind
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // read_value, effective_address
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   back_status_type status;
   cmd_type         push_cmd;
   cmd_type         pop_cmd;
   logic            q_push;
   logic            q_full;
   logic            q_pop;
   logic            q_empty;

   oau_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   oau_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   oau_back #(
      .ADDR_BITS (ADDR_BITS),
      .REG_COUNT (REG_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
